>>> hdl/ssrq_pkg.sv
`default_nettype none
package ssrq_pkg;
  localparam int Blocks = 8;
  localparam int ChunksPerBlock = 4;
  localparam int TotalSlots = Blocks * ChunksPerBlock;
  localparam int SlotW = $clog2(TotalSlots);
  localparam int BlockW = (Blocks > 1) ? $clog2(Blocks) : 1;
  localparam int ChunkW = (ChunksPerBlock > 1) ? $clog2(ChunksPerBlock) : 1;
  localparam int CntW = SlotW + 1;
  localparam logic [3:0] MapExcl = 4'd15;

  localparam logic [1:0] AddrResendInterval = 2'd0;

  localparam logic [1:0] StFree = 2'd0;
  localparam logic [1:0] StUsed = 2'd1;
  localparam logic [1:0] StSent = 2'd2;

  localparam logic [2:0] ActAllocSmall = 3'd0;
  localparam logic [2:0] ActAllocBig   = 3'd1;
  localparam logic [2:0] ActRecord     = 3'd2;
  localparam logic [2:0] ActRelease    = 3'd3;
  localparam logic [2:0] ActResend     = 3'd4;
  localparam logic [2:0] ActAck        = 3'd5;
  localparam logic [2:0] ActDrop       = 3'd6;

  localparam logic [2:0] KindAllocOk   = 3'd0;
  localparam logic [2:0] KindAllocFail = 3'd1;
  localparam logic [2:0] KindResendDue = 3'd2;
  localparam logic [2:0] KindReleased  = 3'd3;
  localparam logic [2:0] KindDone      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SCAN, S_EMIT, S_DONE
  } state_e;
endpackage
`default_nettype wire

>>> hdl/ssrq_ram.sv
`default_nettype none
module ssrq_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/segment_slot_retransmit_queue.sv
// Retransmit slot queue.
// Input stream s_axis: tdata = action[2:0], slot[7:3], seq_number[39:8],
// current_time[71:40], ack_point[103:72]. One transaction is one action.
// Output stream m_axis: tdata = kind, result_slot, try_count, slot_seq;
// tlast marks the final result of an action.
// APB port writes resend_interval at address 0.
// Each action is run by a sequencer around one shared slot unit that
// reads slot data from block RAMs one slot at a time (read, then
// evaluate/write). Scan actions visit all 32 slots, and drop first reads
// the given slot. Allocation stops at the first free slot; record and
// release visit only the given slot.
// s_axis_tready is high only when idle. A stalled m_axis receiver holds
// the sequencer on the pending result; nothing is dropped.
// After reset all slots and blocks are free and resend_interval is 1;
// seq, time and try stores are undefined until a slot is recorded sent.
`default_nettype none
module segment_slot_retransmit_queue
  import ssrq_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,  // action,slot,seq,time,ack
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // kind,result_slot,try_count,slot_seq
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  state_e state_q, state_d;
  logic [15:0] interval_q;
  logic [1:0] status_q [TotalSlots];
  logic [3:0] map_q [Blocks];
  logic [2:0] act_q;
  logic [SlotW-1:0] slot_q, idx_q;
  logic [31:0] seq_q, now_q, ack_q, drop_q;
  logic first_q;
  logic [2:0] okind_q;
  logic [SlotW-1:0] oslot_q;
  logic [7:0] otry_q;
  logic [31:0] oseq_q;
  logic olast_q;

  logic seq_we, tm_we, tr_we;
  logic [31:0] seq_wd, tm_wd;
  logic [7:0] tr_wd;
  logic [SlotW-1:0] waddr, raddr;
  logic [31:0] seq_rd, tm_rd;
  logic [7:0] tr_rd;

  ssrq_ram #(.Width(32), .Depth(TotalSlots)) u_seq (.clk_i, .we_i(seq_we),
    .waddr_i(waddr), .wdata_i(seq_wd), .raddr_i(raddr), .rdata_o(seq_rd));
  ssrq_ram #(.Width(32), .Depth(TotalSlots)) u_tm (.clk_i, .we_i(tm_we),
    .waddr_i(waddr), .wdata_i(tm_wd), .raddr_i(raddr), .rdata_o(tm_rd));
  ssrq_ram #(.Width(8), .Depth(TotalSlots)) u_tr (.clk_i, .we_i(tr_we),
    .waddr_i(waddr), .wdata_i(tr_wd), .raddr_i(raddr), .rdata_o(tr_rd));

  assign pready = 1'b1;
  assign prdata = {16'd0, interval_q};
  wire s_hs = s_axis_tvalid && s_axis_tready;
  wire m_hs = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_EMIT) || (state_q == S_DONE);
  assign m_axis_tlast = (state_q == S_DONE) ? 1'b1 : olast_q;
  assign m_axis_tdata = (state_q == S_DONE) ?
    {32'd0, 8'd0, 5'd0, KindDone} : {oseq_q, otry_q, oslot_q, okind_q};

  wire [BlockW-1:0] blk = BlockW'(idx_q / ChunksPerBlock);
  wire [ChunkW-1:0] chk = ChunkW'(idx_q % ChunksPerBlock);
  wire [3:0] map_b = map_q[blk];
  wire [1:0] st = status_q[idx_q];
  wire scanned = (map_b != 4'd0) && !(map_b == MapExcl && chk != '0);
  wire last_idx = (idx_q == SlotW'(TotalSlots - 1));
  wire [7:0] tr_inc = (tr_rd == 8'hFF) ? tr_rd : tr_rd + 8'd1;
  wire [31:0] mul = 32'(interval_q) * 32'(tr_inc);

  // per-slot decision of the shared unit
  logic hit, fin;
  always_comb begin
    hit = 1'b0;
    fin = 1'b0;
    case (act_q)
      ActAllocSmall: begin
        hit = (map_b < 4'(ChunksPerBlock)) && st == StFree;
        fin = hit;
      end
      ActAllocBig: begin
        hit = (chk == '0) && map_b == 4'd0;
        fin = hit;
      end
      ActRecord: fin = 1'b1;
      ActRelease: begin
        hit = (st != StFree);
        fin = 1'b1;
      end
      ActResend: hit = scanned && st == StSent && now_q >= tm_rd;
      ActAck: hit = scanned && st == StSent && seq_rd <= ack_q;
      ActDrop: hit = map_b != 4'd0 && map_b != MapExcl && idx_q != slot_q &&
                     st != StFree && seq_rd == drop_q;
      default: fin = 1'b1;
    endcase
  end

  wire single = (act_q == ActRecord) || (act_q == ActRelease) || (act_q > ActDrop);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_hs) state_d = S_RD;
      S_RD: state_d = S_SCAN;
      S_SCAN: begin
        if (act_q == ActDrop && first_q) state_d = S_RD;
        else if (hit && (act_q == ActAllocSmall || act_q == ActAllocBig ||
                 act_q == ActRelease)) state_d = S_EMIT;
        else if (hit && act_q != ActRecord) state_d = S_EMIT;
        else if (fin || last_idx) begin
          state_d = (!fin && (act_q == ActAllocSmall || act_q == ActAllocBig))
                    ? S_EMIT : S_DONE;
        end else state_d = S_RD;
      end
      S_EMIT: if (m_hs) begin
        if (olast_q) state_d = S_IDLE;
        else if (last_idx) state_d = S_DONE;
        else state_d = S_RD;
      end
      S_DONE: if (m_hs) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  wire in_scan = (state_q == S_SCAN) && !(act_q == ActDrop && first_q);
  always_comb begin
    raddr = idx_q;
    waddr = idx_q;
    seq_we = in_scan && act_q == ActRecord && st != StFree;
    seq_wd = seq_q;
    tr_we = seq_we || (in_scan && act_q == ActResend && hit);
    tr_wd = seq_we ? 8'd0 : tr_inc;
    tm_we = tr_we;
    tm_wd = seq_we ? 32'd0 : now_q + mul;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      interval_q <= 16'd1;
      for (int i = 0; i < TotalSlots; i++) status_q[i] <= StFree;
      for (int i = 0; i < Blocks; i++) map_q[i] <= 4'd0;
      act_q <= ActAllocSmall;
      idx_q <= '0;
      first_q <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && paddr == AddrResendInterval)
        interval_q <= pwdata[15:0];
      case (state_q)
        S_IDLE: if (s_hs) begin
          act_q <= s_axis_tdata[2:0];
          slot_q <= s_axis_tdata[7:3];
          seq_q <= s_axis_tdata[39:8];
          now_q <= s_axis_tdata[71:40];
          ack_q <= s_axis_tdata[103:72];
          first_q <= (s_axis_tdata[2:0] == ActDrop);
          idx_q <= (s_axis_tdata[2:0] == ActRecord || s_axis_tdata[2:0] == ActRelease
                    || s_axis_tdata[2:0] == ActDrop) ? s_axis_tdata[7:3] : '0;
        end
        S_SCAN: begin
          if (act_q == ActDrop && first_q) begin
            first_q <= 1'b0;
            drop_q <= seq_rd;
            idx_q <= '0;
          end else begin
            olast_q <= single || act_q == ActAllocSmall || act_q == ActAllocBig;
            if (act_q == ActAllocSmall || act_q == ActAllocBig) begin
              okind_q <= hit ? KindAllocOk : KindAllocFail;
              oslot_q <= hit ? idx_q : '0;
              otry_q <= 8'd0;
              oseq_q <= 32'd0;
            end else if (act_q == ActResend) begin
              okind_q <= KindResendDue;
              oslot_q <= idx_q;
              otry_q <= tr_inc;
              oseq_q <= seq_rd;
            end else begin
              okind_q <= KindReleased;
              oslot_q <= idx_q;
              otry_q <= 8'd0;
              oseq_q <= seq_rd;
            end
            if (act_q == ActRecord && st != StFree) status_q[idx_q] <= StSent;
            if (hit) begin
              case (act_q)
                ActAllocSmall: begin
                  status_q[idx_q] <= StUsed;
                  map_q[blk] <= map_b + 4'd1;
                end
                ActAllocBig: begin
                  status_q[idx_q] <= StUsed;
                  map_q[blk] <= MapExcl;
                end
                ActRelease, ActAck, ActDrop: begin
                  status_q[idx_q] <= StFree;
                  map_q[blk] <= (map_b == MapExcl) ? 4'd0 :
                                (map_b != 4'd0) ? map_b - 4'd1 : 4'd0;
                end
                default: ;
              endcase
            end else if (!fin && !last_idx) idx_q <= idx_q + 1'b1;
          end
        end
        S_EMIT: if (m_hs && !olast_q && !last_idx) idx_q <= idx_q + 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
